/* rtl/core/double_hash_table_insert_search_defines.svh */
// Assertion macros for the checker file.
`ifndef DOUBLE_HASH_TABLE_INSERT_SEARCH_DEFINES_SVH
`define DOUBLE_HASH_TABLE_INSERT_SEARCH_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define DHTIS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hash table check failed");

// Next-cycle implication, off while reset is asserted
`define DHTIS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hash table check failed");

// Next-cycle implication that also holds through reset
`define DHTIS_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

/* rtl/core/dhtis_pkg.sv */
package dhtis_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 50;
    localparam int KEY_BYTES   = 8;
    localparam int KEY_W       = 64;
    localparam int STEP_MOD    = 7;

    // Derived widths
    localparam int SLOT_W     = $clog2(TABLE_SLOTS);
    localparam int IDX1_W     = SLOT_W + 1;
    localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
    localparam int SUM_W      = $clog2(KEY_BYTES * 255 + 1);
    localparam int MOD_W      = (SUM_W > IDX1_W) ? SUM_W : IDX1_W;
    localparam int PROD_W     = SUM_W + MOD_W;
    localparam int STEP_W     = 3;
    localparam int SLOT_OUT_W = 6;
    localparam int OUT_DATA_W = 8;

    // Keep only the low KEY_BYTES bytes of a key
    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

    // Reciprocals for the constant modulo: floor(2^SUM_W / d) leaves the
    // quotient at most one short, so one compare-subtract finishes it
    localparam logic [SUM_W-1:0] RECIP_T = SUM_W'((1 << SUM_W) / TABLE_SLOTS);
    localparam logic [SUM_W-1:0] RECIP_7 = SUM_W'((1 << SUM_W) / STEP_MOD);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_key;
        logic    calc_sum;
        logic    calc_quo;
        logic    calc_home;
        logic    advance;
        logic    write_slot;
        logic    load_out;
        status_t res_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_used;
        logic key_match;
        logic probes_done;
    } dp_sts_t;

endpackage

/* rtl/core/double_hash_table_insert_search.sv */
// Channel   Dir  tdata (low bit up)        tuser          Handshake
// s_        in   key[63:0]                 cmd[0]         s_tvalid/s_tready
// m_        out  slot[5:0], 2'b0 pad       status[1:0]    m_tvalid/m_tready
//
// One request at a time. Accept, byte sum, quotient and home slot each take a state,
// then each probe takes the probe state (insert, or an empty slot) or the probe and
// compare states (search reading a used slot through the single key RAM read port),
// and the result its own state. There are P probes, P at most TABLE_SLOTS, and the
// probe state is entered once more when all of them pass with no empty slot.
// Reset empties the table at once through per-slot valid flops.
// A result waiting in the output register does not stall a new request; a
// finished request waits only if the previous result is still not taken.
module double_hash_table_insert_search
    import dhtis_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KEY_W-1:0]      s_tdata,   // key
    input  logic [0:0]            s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // slot, zero pad
    output logic [1:0]            m_tuser    // status
);

    dp_cmd_t               dp_cmd;
    dp_sts_t               dp_sts;
    status_t               status_out;
    logic [SLOT_OUT_W-1:0] slot_out;

    dhtis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd),
        .dp_sts   (dp_sts)
    );

    dhtis_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dp_cmd     (dp_cmd),
        .dp_sts     (dp_sts),
        .key_in     (s_tdata),
        .status_out (status_out),
        .slot_out   (slot_out)
    );

    assign m_tdata = {{(OUT_DATA_W - SLOT_OUT_W){1'b0}}, slot_out};
    assign m_tuser = status_out;

endmodule

/* rtl/core/dhtis_ram.sv */
module dhtis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/dhtis_dp.sv */
module dhtis_dp
    import dhtis_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               dp_cmd,
    output dp_sts_t               dp_sts,
    input  logic [KEY_W-1:0]      key_in,
    output status_t               status_out,
    output logic [SLOT_OUT_W-1:0] slot_out
);

    logic [KEY_W-1:0]      key_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      qt_reg;
    logic [SUM_W-1:0]      q7_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     idx_next;
    logic [STEP_W-1:0]     step_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [TABLE_SLOTS-1:0] used_reg;
    status_t               status_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;

    logic [SUM_W-1:0]  byte_sum;
    logic [PROD_W-1:0] prod_t;
    logic [PROD_W-1:0] prod_7;
    logic [PROD_W-1:0] back_t;
    logic [PROD_W-1:0] back_7;
    logic [MOD_W-1:0]  rem_t;
    logic [MOD_W-1:0]  home;
    logic [SUM_W-1:0]  rem_7;
    logic [SUM_W-1:0]  rem_7_fix;
    logic [IDX1_W-1:0] idx_sum;
    logic [IDX1_W-1:0] idx_wrap;
    logic [KEY_W-1:0]  ram_rdata;

    // Add up the key bytes
    always_comb begin
        byte_sum = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            byte_sum = byte_sum + SUM_W'(key_reg[8*b +: 8]);
        end
    end

    // Estimate both quotients by reciprocal
    assign prod_t = PROD_W'(sum_reg) * PROD_W'(RECIP_T);
    assign prod_7 = PROD_W'(sum_reg) * PROD_W'(RECIP_7);

    // Form remainders, correct by one subtract
    assign back_t    = PROD_W'(qt_reg) * PROD_W'(TABLE_SLOTS);
    assign back_7    = PROD_W'(q7_reg) * PROD_W'(STEP_MOD);
    assign rem_t     = MOD_W'(sum_reg) - back_t[MOD_W-1:0];
    assign home      = (rem_t >= MOD_W'(TABLE_SLOTS)) ? rem_t - MOD_W'(TABLE_SLOTS) : rem_t;
    assign rem_7     = sum_reg - back_7[SUM_W-1:0];
    assign rem_7_fix = (rem_7 >= SUM_W'(STEP_MOD)) ? rem_7 - SUM_W'(STEP_MOD) : rem_7;

    // Advance along the probe sequence, wrap once
    assign idx_sum  = {1'b0, idx_reg} + IDX1_W'(step_reg);
    assign idx_wrap = (idx_sum >= IDX1_W'(TABLE_SLOTS)) ? idx_sum - IDX1_W'(TABLE_SLOTS)
                                                        : idx_sum;
    assign idx_next = dp_cmd.calc_home ? home[SLOT_W-1:0] : idx_wrap[SLOT_W-1:0];

    // Hold key, hash terms, probe position and result
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_key) begin
            key_reg <= key_in & KEY_MASK;
        end
        if (dp_cmd.calc_sum) begin
            sum_reg <= byte_sum;
        end
        if (dp_cmd.calc_quo) begin
            qt_reg <= prod_t[SUM_W +: SUM_W];
            q7_reg <= prod_7[SUM_W +: SUM_W];
        end
        if (dp_cmd.calc_home) begin
            step_reg <= STEP_W'(SUM_W'(STEP_MOD) - rem_7_fix);
            cnt_reg  <= '0;
        end else if (dp_cmd.advance) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (dp_cmd.calc_home || dp_cmd.advance) begin
            idx_reg <= idx_next;
        end
        if (dp_cmd.load_out) begin
            status_reg <= dp_cmd.res_status;
            if (dp_cmd.res_status == ST_INSERTED || dp_cmd.res_status == ST_FOUND) begin
                slot_reg <= SLOT_OUT_W'(idx_reg);
            end else begin
                slot_reg <= '0;
            end
        end
    end

    // Mark slots taken; reset empties the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (dp_cmd.write_slot) begin
            used_reg[idx_reg] <= 1'b1;
        end
    end

    dhtis_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .clk   (aclk),
        .we    (dp_cmd.write_slot),
        .waddr (idx_reg),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign dp_sts.slot_used   = used_reg[idx_reg];
    assign dp_sts.key_match   = (ram_rdata == key_reg);
    assign dp_sts.probes_done = (cnt_reg == CNT_W'(TABLE_SLOTS));

    assign status_out = status_reg;
    assign slot_out   = slot_reg;

endmodule

/* rtl/core/dhtis_ctrl.sv */
module dhtis_ctrl
    import dhtis_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    s_op,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t dp_cmd,
    input  dp_sts_t dp_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_QUO,
        S_HOME,
        S_PROBE,
        S_CMP,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    op_t     op_reg, op_next;
    status_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;

    // Sequence one request through hash, probe and result
    always_comb begin
        dp_cmd     = '0;
        state_next = state_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    dp_cmd.load_key = 1'b1;
                    op_next         = op_t'(s_op);
                    state_next      = S_SUM;
                end
            end
            S_SUM: begin
                dp_cmd.calc_sum = 1'b1;
                state_next      = S_QUO;
            end
            S_QUO: begin
                dp_cmd.calc_quo = 1'b1;
                state_next      = S_HOME;
            end
            S_HOME: begin
                dp_cmd.calc_home = 1'b1;
                state_next       = S_PROBE;
            end
            S_PROBE: begin
                if (dp_sts.probes_done) begin
                    res_next   = (op_reg == OP_SEARCH) ? ST_MISSING : ST_FULL;
                    state_next = S_DONE;
                end else if (!dp_sts.slot_used) begin
                    if (op_reg == OP_INSERT) begin
                        dp_cmd.write_slot = 1'b1;
                        res_next          = ST_INSERTED;
                    end else begin
                        res_next = ST_MISSING;
                    end
                    state_next = S_DONE;
                end else if (op_reg == OP_INSERT) begin
                    dp_cmd.advance = 1'b1;
                end else begin
                    // key read issued this cycle, compare next
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (dp_sts.key_match) begin
                    res_next   = ST_FOUND;
                    state_next = S_DONE;
                end else begin
                    dp_cmd.advance = 1'b1;
                    state_next     = S_PROBE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    dp_cmd.load_out   = 1'b1;
                    dp_cmd.res_status = res_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set on a new result, drop once the beat is taken
    always_comb begin
        if (dp_cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_INSERT;
            res_reg       <= ST_INSERTED;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

/* rtl/core/dhtis_chk.sv */
`include "double_hash_table_insert_search_defines.svh"

module dhtis_chk
    import dhtis_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser
);

    logic miss_beat;

    // A stalled result beat stays up
    `DHTIS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // A miss or a full table reports slot zero
    assign miss_beat = m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_MISSING);
    `DHTIS_ASSERT_IMP(a_miss_slot, aclk, aresetn, miss_beat, m_tdata == '0)

    // Block goes busy once a request is taken
    `DHTIS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Reset leaves no result pending
    `DHTIS_ASSERT_ALW(a_reset_quiet, aclk, !aresetn, !m_tvalid)

endmodule

bind double_hash_table_insert_search dhtis_chk u_dhtis_chk (.*);

/* dv/double_hash_table_insert_search_test.sv */
module double_hash_table_insert_search_test;
    import dhtis_pkg::*;

    localparam int STALL_PCT    = 13;
    localparam int RANDOM_REQS  = 1330;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 250;
    localparam int POOL_DEPTH   = 64;

    typedef struct {
        status_t                 status;
        logic [SLOT_OUT_W-1:0]   slot;
    } lookup_result_t;

    typedef struct {
        op_t                     op;
        logic [KEY_W-1:0]        key;
        bit                      typed;
        status_t                 status;
        logic [SLOT_OUT_W-1:0]   slot;
    } plan_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata  = '0;   // key
    logic [0:0]            s_tuser  = '0;   // cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // slot[5:0], zero pad
    logic [1:0]            m_tuser;         // status

    // Shadow copy of the table
    logic [KEY_W-1:0] shadow_keys [TABLE_SLOTS];
    bit               shadow_used [TABLE_SLOTS];

    lookup_result_t   pending_results [$];
    logic [KEY_W-1:0] key_pool [$];
    bit               calm = 1'b0;
    int               errors = 0;
    int               quiet_cycles = 0;

    // Sum-100 keys all hash to home 0 with step 5, so they share a
    // ten-slot probe path that fills up long before the table does
    plan_row_t directed_plan [23] = '{
        '{OP_SEARCH, 64'h0,                   1'b1, ST_MISSING,  6'd0},
        '{OP_INSERT, 64'h0,                   1'b1, ST_INSERTED, 6'd0},
        '{OP_SEARCH, 64'h0,                   1'b1, ST_FOUND,    6'd0},
        '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_INSERTED, 6'd40},
        '{OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_FOUND,    6'd40},
        '{OP_INSERT, 64'h0,                   1'b0, ST_INSERTED, 6'd0},
        '{OP_SEARCH, 64'h100,                 1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h1,                   1'b0, ST_INSERTED, 6'd0},
        '{OP_SEARCH, 64'h100,                 1'b0, ST_INSERTED, 6'd0},
        '{OP_SEARCH, 64'h8000_0000_0000_0000, 1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h64,                  1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h6400,                1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h64_0000,             1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h6400_0000,           1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h64_0000_0000,        1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h6400_0000_0000,      1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h64_0000_0000_0000,   1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h6400_0000_0000_0000, 1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h3232,                1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h0163,                1'b0, ST_INSERTED, 6'd0},
        '{OP_INSERT, 64'h1919_1919,           1'b1, ST_FULL,     6'd0},
        '{OP_SEARCH, 64'h2020_2004,           1'b0, ST_INSERTED, 6'd0},
        '{OP_SEARCH, 64'h6400,                1'b0, ST_INSERTED, 6'd0}
    };

    double_hash_table_insert_search u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Probe the shadow table along the double-hash path and update it
    function automatic lookup_result_t hash_lookup(op_t op, logic [KEY_W-1:0] raw_key);
        logic [KEY_W-1:0] key;
        int               sum;
        int               home;
        int               step;
        int               idx;
        lookup_result_t   res;
        key = raw_key & KEY_MASK;
        sum = 0;
        for (int b = 0; b < 8; b++) sum += key[8*b +: 8];
        home = sum % TABLE_SLOTS;
        step = STEP_MOD - (sum % STEP_MOD);
        res.status = (op == OP_INSERT) ? ST_FULL : ST_MISSING;
        res.slot = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            idx = (home + i * step) % TABLE_SLOTS;
            if (!shadow_used[idx]) begin
                if (op == OP_INSERT) begin
                    shadow_used[idx] = 1'b1;
                    shadow_keys[idx] = key;
                    res.status = ST_INSERTED;
                    res.slot = SLOT_OUT_W'(idx);
                end
                break;
            end
            if (op == OP_SEARCH && shadow_keys[idx] == key) begin
                res.status = ST_FOUND;
                res.slot = SLOT_OUT_W'(idx);
                break;
            end
        end
        return res;
    endfunction

    // Mix of stored keys, same-sum variants, sparse keys, extremes and noise
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int               roll;
        int               r;
        roll = $urandom_range(99);
        k = {$urandom, $urandom};
        if (key_pool.size() != 0 && roll < 35) begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        end else if (key_pool.size() != 0 && roll < 50) begin
            // rotate bytes: same hash, different key
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            r = $urandom_range(7, 1);
            k = (k << (8 * r)) | (k >> (64 - 8 * r));
        end else if (roll < 75) begin
            k = '0;
            repeat ($urandom_range(3, 1)) k[8 * $urandom_range(7) +: 8] = 8'($urandom);
        end else if (roll < 85) begin
            case ($urandom_range(2))
                0: k = '0;
                1: k = '1;
                default: k = 64'h1 << $urandom_range(63);
            endcase
        end
        return k;
    endfunction

    // Present one request, wait until it is accepted, then log its expected result
    task automatic send_request(op_t op, logic [KEY_W-1:0] key, bit typed, status_t st,
                                logic [SLOT_OUT_W-1:0] slot);
        lookup_result_t want;
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = hash_lookup(op, key);
        if (typed) begin
            want.status = st;
            want.slot = slot;
        end
        pending_results.push_back(want);
        if (op == OP_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
        end
    endtask

    // Hold the input idle until every outstanding result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_plan[i])
            send_request(directed_plan[i].op, directed_plan[i].key, directed_plan[i].typed,
                         directed_plan[i].status, directed_plan[i].slot);
        drain_results();
        for (int n = 0; n < RANDOM_REQS; n++) begin
            calm = (n >= 400 && n < 600);
            if (n == 700) drain_results();
            send_request(($urandom_range(99) < 40) ? OP_INSERT : OP_SEARCH, pick_key(),
                         1'b0, ST_INSERTED, '0);
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("double_hash_table_insert_search verification clean");
        end else begin
            $display("double_hash_table_insert_search verification failed");
        end
        $finish;
    end

    // Result side: random backpressure and compare against the oldest expectation
    always @(posedge aclk) begin
        lookup_result_t want;
        m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d slot %0d",
                       m_tuser, m_tdata[SLOT_OUT_W-1:0]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[SLOT_OUT_W-1:0] !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot,
                           m_tdata[SLOT_OUT_W-1:0]);
                    errors++;
                end
                if (m_tdata[OUT_DATA_W-1:SLOT_OUT_W] !== '0) begin
                    $error("pad: expected 0, got %0h", m_tdata[OUT_DATA_W-1:SLOT_OUT_W]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("double_hash_table_insert_search verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
